[design/bpot_pkg.sv]
// ----------------------------------------------------------------------------
// Box portal overlap test package
// Shared request types, widths and register indexes for the overlap pipeline.
// ----------------------------------------------------------------------------
package bpot_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int POS_SHIFT  = 2;
    localparam int SIZE_W     = 15;
    localparam int QSIZE_W    = SIZE_W - POS_SHIFT;
    localparam int LANE_W     = 16;
    localparam int ROW_W      = 3 * LANE_W;
    localparam int PROD_W     = LANE_W + QSIZE_W + 1;
    localparam int FLOOR_W    = PROD_W - FRAC_BITS;
    localparam int MAG_W      = 17;
    localparam int EXT_W      = 18;
    localparam int POS_W      = 32;
    localparam int TPOS_W     = POS_W - POS_SHIFT;
    localparam int DIFF_W     = POS_W + 1;
    localparam int HALF_W     = 31;
    localparam int CMP_W      = 35;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_POS_X  = 3'd0;
    localparam logic [2:0] REG_POS_Y  = 3'd1;
    localparam logic [2:0] REG_POS_Z  = 3'd2;
    localparam logic [2:0] REG_HALF_X = 3'd3;
    localparam logic [2:0] REG_HALF_Y = 3'd4;
    localparam logic [2:0] REG_HALF_Z = 3'd5;

    typedef struct packed {
        logic [ROW_W-1:0]         matrix_row0;
        logic [ROW_W-1:0]         matrix_row1;
        logic [ROW_W-1:0]         matrix_row2;
        logic [SIZE_W-1:0]        box_size_x;
        logic [SIZE_W-1:0]        box_size_y;
        logic [SIZE_W-1:0]        box_size_z;
        logic signed [POS_W-1:0]  box_pos_x;
        logic signed [POS_W-1:0]  box_pos_y;
        logic signed [POS_W-1:0]  box_pos_z;
    } t_in_req;

    typedef struct packed {
        logic             hit;
        logic [EXT_W-1:0] extent_x;
        logic [EXT_W-1:0] extent_y;
        logic [EXT_W-1:0] extent_z;
    } t_out_req;

    // Load enables of the three stages inside the extent unit.
    typedef struct packed {
        logic a;
        logic b;
        logic c;
    } t_stage_en;

endpackage

[design/bpot_ext.sv]
// ----------------------------------------------------------------------------
// Box portal overlap test: bound extents
// Three-stage pipeline that turns a rotation and a box size into the
// half-extents of the box's axis-aligned bound.
// ----------------------------------------------------------------------------
module bpot_ext
    import bpot_pkg::*;
(
    input  logic                  i_clk,
    input  t_stage_en             i_en,
    input  logic [ROW_W-1:0]      i_row [3],
    input  logic [SIZE_W-1:0]     i_size [3],
    output logic [EXT_W-1:0]      o_ext [3]
);

    logic signed [PROD_W-1:0]  r_prod [3][3];
    logic signed [PROD_W-1:0]  n_prod [3][3];
    logic [MAG_W-1:0]          r_mag [3][3];
    logic [MAG_W-1:0]          n_mag [3][3];
    logic [EXT_W-1:0]          r_ext [3];
    logic [EXT_W-1:0]          n_ext [3];

    // Stage A: one 16 by 14 bit signed product per matrix entry.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_prod[r][c] = $signed(i_row[r][c*LANE_W +: LANE_W])
                             * $signed({1'b0, i_size[c][SIZE_W-1:POS_SHIFT]});
            end
        end
    end

    // Stage B: floor by the arithmetic shift, then the magnitude.
    always_comb begin
        logic signed [FLOOR_W-1:0] fl;
        logic [FLOOR_W-1:0]        ab;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                fl = r_prod[r][c][PROD_W-1:FRAC_BITS];
                ab = fl[FLOOR_W-1] ? FLOOR_W'(-fl) : FLOOR_W'(fl);
                n_mag[r][c] = ab[MAG_W-1:0];
            end
        end
    end

    // Stage C: sum over each row.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_ext[r] = EXT_W'(r_mag[r][0]) + EXT_W'(r_mag[r][1]) + EXT_W'(r_mag[r][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.a) begin
            r_prod <= n_prod;
        end
        if (i_en.b) begin
            r_mag <= n_mag;
        end
        if (i_en.c) begin
            r_ext <= n_ext;
        end
    end

    assign o_ext = r_ext;

endmodule

[design/box_portal_overlap_test_top.sv]
// ----------------------------------------------------------------------------
// Box portal overlap test
// Tests an oriented box against a configured axis-aligned rectangle.
// ----------------------------------------------------------------------------
// The block takes one oriented box per request (a 4.12 rotation, a size and a
// position in quarter world units) and returns one result per request: the
// half-extents of the box's axis-aligned bound and a hit flag that is set when
// that bound touches or overlaps the configured rectangle. The rectangle lies
// in the plane picked by its first zero half-extent (x, then y, otherwise z).
// A new box is accepted in every cycle in which o_in_stall is low; each one
// passes through the stages product, floor and magnitude, row sum, and
// overlap compare with the output register, in that order. Each stage holds
// only while the stage after it is full and held, so bubbles close up and a
// stalled result does not stop new boxes entering empty stages. The rectangle
// registers sit on an APB-style port and must only be written while no
// request is in flight.
// ----------------------------------------------------------------------------
module box_portal_overlap_test_top
    import bpot_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_req             i_in_data,

    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_req            o_out_data,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    // Configuration registers.
    logic signed [POS_W-1:0] r_rect_pos [3];
    logic [HALF_W-1:0]       r_rect_half [3];

    // Pipeline valid bits, one per stage.
    logic r_va, r_vb, r_vc, r_vd;
    logic en_a, en_b, en_c, en_d;

    // Position path payload.
    logic signed [TPOS_W-1:0] r_tpos [3];
    logic signed [TPOS_W-1:0] n_tpos [3];
    logic signed [DIFF_W-1:0] r_diff_b [3];
    logic signed [DIFF_W-1:0] n_diff_b [3];
    logic signed [DIFF_W-1:0] r_diff_c [3];

    logic [ROW_W-1:0]  row [3];
    logic [SIZE_W-1:0] size [3];
    logic [EXT_W-1:0]  ext [3];
    t_stage_en         stage_en;

    t_out_req r_out;
    t_out_req n_out;

    logic [2:0] reg_idx;
    logic       cfg_wr;

    // ------------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; pready is tied
    // high so there are never wait states.
    // ------------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_rect_pos[i]  <= '0;
                r_rect_half[i] <= '0;
            end
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_POS_X:  r_rect_pos[0]  <= pwdata;
                REG_POS_Y:  r_rect_pos[1]  <= pwdata;
                REG_POS_Z:  r_rect_pos[2]  <= pwdata;
                REG_HALF_X: r_rect_half[0] <= pwdata[HALF_W-1:0];
                REG_HALF_Y: r_rect_half[1] <= pwdata[HALF_W-1:0];
                REG_HALF_Z: r_rect_half[2] <= pwdata[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_POS_X:  prdata = r_rect_pos[0];
            REG_POS_Y:  prdata = r_rect_pos[1];
            REG_POS_Z:  prdata = r_rect_pos[2];
            REG_HALF_X: prdata = {1'b0, r_rect_half[0]};
            REG_HALF_Y: prdata = {1'b0, r_rect_half[1]};
            REG_HALF_Z: prdata = {1'b0, r_rect_half[2]};
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Flow control. A stage loads when it is empty or when the stage after it
    // is loading as well, so bubbles are squeezed out under back-pressure.
    // ------------------------------------------------------------------------
    assign en_d = !r_vd || !i_out_stall;
    assign en_c = !r_vc || en_d;
    assign en_b = !r_vb || en_c;
    assign en_a = !r_va || en_b;

    assign o_in_stall = !en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_in_valid;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
            if (en_c) begin
                r_vc <= r_vb;
            end
            if (en_d) begin
                r_vd <= r_vc;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Extent path: products, floor and magnitude, and row sums live in the
    // extent unit, which follows the same stage enables.
    // ------------------------------------------------------------------------
    assign row[0]  = i_in_data.matrix_row0;
    assign row[1]  = i_in_data.matrix_row1;
    assign row[2]  = i_in_data.matrix_row2;
    assign size[0] = i_in_data.box_size_x;
    assign size[1] = i_in_data.box_size_y;
    assign size[2] = i_in_data.box_size_z;

    assign stage_en.a = en_a;
    assign stage_en.b = en_b;
    assign stage_en.c = en_c;

    bpot_ext u_ext (
        .i_clk  (i_clk),
        .i_en   (stage_en),
        .i_row  (row),
        .i_size (size),
        .o_ext  (ext)
    );

    // ------------------------------------------------------------------------
    // Position path. Stage A divides the box position by four, rounding toward
    // zero: negative values are biased by three before the arithmetic shift.
    // Stage B forms the rectangle-to-box difference; stage C only carries it
    // alongside the row sums.
    // ------------------------------------------------------------------------
    always_comb begin
        logic signed [POS_W-1:0] pos;
        logic signed [POS_W-1:0] adj;
        for (int i = 0; i < 3; i++) begin
            case (i)
                0:       pos = i_in_data.box_pos_x;
                1:       pos = i_in_data.box_pos_y;
                default: pos = i_in_data.box_pos_z;
            endcase
            adj       = pos + $signed({{(POS_W-2){1'b0}}, pos[POS_W-1], pos[POS_W-1]});
            n_tpos[i] = adj[POS_W-1:POS_SHIFT];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_diff_b[i] = DIFF_W'(r_rect_pos[i]) - DIFF_W'(r_tpos[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_tpos <= n_tpos;
        end
        if (en_b) begin
            r_diff_b <= n_diff_b;
        end
        if (en_c) begin
            r_diff_c <= r_diff_b;
        end
    end

    // ------------------------------------------------------------------------
    // Stage D: overlap compare. On the axis normal to the rectangle's plane
    // the rectangle adds no width; on the other two its half-extent widens
    // the box extent. Touching still counts as a hit.
    // ------------------------------------------------------------------------
    always_comb begin
        logic [HALF_W-1:0]       h [3];
        logic signed [CMP_W-1:0] lim;
        logic signed [CMP_W-1:0] dd;
        logic                    ok;
        h[0] = r_rect_half[0];
        h[1] = r_rect_half[1];
        h[2] = r_rect_half[2];
        if (r_rect_half[0] == '0) begin
            h[0] = '0;
        end else if (r_rect_half[1] == '0) begin
            h[1] = '0;
        end else begin
            h[2] = '0;
        end
        ok = 1'b1;
        for (int i = 0; i < 3; i++) begin
            lim = $signed(CMP_W'(ext[i])) + $signed(CMP_W'(h[i]));
            dd  = CMP_W'(r_diff_c[i]);
            if ((dd > lim) || (dd < -lim)) begin
                ok = 1'b0;
            end
        end
        n_out.hit      = ok;
        n_out.extent_x = ext[0];
        n_out.extent_y = ext[1];
        n_out.extent_z = ext[2];
    end

    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_vd;
    assign o_out_data  = r_out;

endmodule
